/* src/assert_macros.svh */
// assertion macros for the checker file
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: name");

// next-cycle implication
`define SHI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: name");

`endif

/* src/shi_pkg.sv */
// shared types and constants of the symbol hash index
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shi_pkg;

  localparam int SLOTS  = 512;
  localparam int ROWS   = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int HALF   = SLOTS / 2;

  localparam logic [63:0] GOLDEN   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [7:0]  ROW_MASK = 8'(ROWS - 1);

  localparam logic [1:0] OP_INSERT     = 2'd0;
  localparam logic [1:0] OP_INSERT_ENT = 2'd1;
  localparam logic [1:0] OP_LOOKUP     = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [7:0]  row_index;
    logic        valence;
    logic [8:0]  entry_index;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] row_out;
    logic       entry_valid;
    logic [8:0] entry_out;
    logic       status;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] idx;
  } ent_t;

  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [7:0]  row;
    ent_t        dyad;
    ent_t        monad;
  } slot_t;

endpackage

`default_nettype wire

/* src/symbol_hash_index.sv */
// symbol hash index top level: slot memory, probe sequencer, result register
// depends on shi_pkg and shi_hash
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input: in_item is taken at a rising edge with start high and busy low.
//   output: out_valid pulses for one cycle with out_item; there is no stall.
//   ops: insert, insert with entry at valence, lookup, clear all.
// timing
//   one item at a time. an insert or lookup goes through ST_HASH_A, ST_HASH_B,
//   ST_READ and ST_CHECK from acceptance to the registered result when the
//   home slot holds the key or is free; each further slot walked by linear
//   probing adds a read and check. the slot memory gives one read per cycle.
//   the result shows in the cycle busy drops, so start may follow at once.
//   clear all walks the slot memory once, writing each slot empty.
// reset
//   after rst_n the same pass empties the memory with busy high;
//   no result is given for it.
module symbol_hash_index (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire shi_pkg::in_t   in_item,
  output logic                out_valid,
  output shi_pkg::out_t       out_item
);

  localparam int W = shi_pkg::SLOT_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_HASH_A = 6'b000010,
    ST_HASH_B = 6'b000100,
    ST_READ   = 6'b001000,
    ST_CHECK  = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [63:0]     key_r, key_nxt;
  logic [7:0]      row_r, row_nxt;
  logic            val_r, val_nxt;
  logic [8:0]      ent_r, ent_nxt;
  logic [W-1:0]    idx_r, idx_nxt;
  logic [W-1:0]    probe_n_r, probe_n_nxt;
  logic [W-1:0]    used_cnt_r, used_cnt_nxt;
  logic [W-1:0]    clr_addr_r, clr_addr_nxt;
  logic            clr_rep_r, clr_rep_nxt;
  logic            out_valid_r, out_valid_nxt;
  shi_pkg::out_t   out_r, out_nxt;

  shi_pkg::slot_t  mem [shi_pkg::SLOTS];
  shi_pkg::slot_t  rd_r;
  logic            mem_re;
  logic [W-1:0]    mem_ra;
  logic            mem_we;
  logic [W-1:0]    mem_wa;
  shi_pkg::slot_t  mem_wd;

  logic [W-1:0]    home;
  logic            hit;
  logic            empty;
  logic            last;
  logic            is_ins;
  logic            full;
  shi_pkg::slot_t  upd;
  shi_pkg::slot_t  rep_src;
  shi_pkg::ent_t   sel;
  shi_pkg::out_t   rep;

  shi_hash u_hash (
    .clk  (clk),
    .key  (key_r),
    .home (home)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_r <= mem[mem_ra];
    end
  end

  assign hit    = rd_r.used && (rd_r.key == key_r);
  assign empty  = !rd_r.used;
  assign last   = (probe_n_r == W'(shi_pkg::SLOTS - 1));
  assign is_ins = (op_r != shi_pkg::OP_LOOKUP);
  assign full   = (used_cnt_r >= W'(shi_pkg::HALF));

  // slot after an insert: existing one on a hit, a fresh one otherwise
  always_comb begin
    if (hit) begin
      upd = rd_r;
    end else begin
      upd       = '0;
      upd.used  = 1'b1;
      upd.key   = key_r;
    end
    upd.row = row_r & shi_pkg::ROW_MASK;
    if (op_r == shi_pkg::OP_INSERT_ENT) begin
      if (val_r) begin
        upd.dyad = '{valid: 1'b1, idx: ent_r};
      end else begin
        upd.monad = '{valid: 1'b1, idx: ent_r};
      end
    end
  end

  always_comb begin
    rep_src         = is_ins ? upd : rd_r;
    sel             = val_r ? rep_src.dyad : rep_src.monad;
    rep.found       = 1'b1;
    rep.row_out     = rep_src.row;
    rep.entry_valid = sel.valid;
    rep.entry_out   = sel.valid ? sel.idx : 9'd0;
    rep.status      = 1'b0;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    row_nxt       = row_r;
    val_nxt       = val_r;
    ent_nxt       = ent_r;
    idx_nxt       = idx_r;
    probe_n_nxt   = probe_n_r;
    used_cnt_nxt  = used_cnt_r;
    clr_addr_nxt  = clr_addr_r;
    clr_rep_nxt   = clr_rep_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_re        = 1'b0;
    mem_ra        = idx_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = upd;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_item.op;
          key_nxt = in_item.key;
          row_nxt = in_item.row_index;
          val_nxt = in_item.valence;
          ent_nxt = in_item.entry_index;
          if (in_item.op == shi_pkg::OP_CLEAR) begin
            state_nxt    = ST_CLEAR;
            clr_addr_nxt = '0;
            clr_rep_nxt  = 1'b1;
          end else begin
            state_nxt = ST_HASH_A;
          end
        end
      end
      ST_HASH_A: begin
        state_nxt = ST_HASH_B;
      end
      ST_HASH_B: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        mem_re      = 1'b1;
        mem_ra      = home;
        idx_nxt     = home;
        probe_n_nxt = '0;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) begin
          mem_we        = is_ins;
          out_valid_nxt = 1'b1;
          out_nxt       = rep;
          state_nxt     = ST_IDLE;
        end else if (empty) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          state_nxt     = ST_IDLE;
          if (is_ins) begin
            if (full) begin
              out_nxt.status = 1'b1;
            end else begin
              mem_we       = 1'b1;
              used_cnt_nxt = used_cnt_r + 1'b1;
              out_nxt      = rep;
            end
          end
        end else if (last) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = is_ins;
          state_nxt      = ST_IDLE;
        end else begin
          // occupied by another key: step to the next slot
          mem_re      = 1'b1;
          mem_ra      = idx_r + 1'b1;
          idx_nxt     = idx_r + 1'b1;
          probe_n_nxt = probe_n_r + 1'b1;
        end
      end
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        mem_wd       = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == W'(shi_pkg::SLOTS - 1)) begin
          state_nxt     = ST_IDLE;
          used_cnt_nxt  = '0;
          out_valid_nxt = clr_rep_r;
          out_nxt       = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      used_cnt_r  <= '0;
      clr_addr_r  <= '0;
      clr_rep_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_cnt_r  <= used_cnt_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_rep_r   <= clr_rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    row_r     <= row_nxt;
    val_r     <= val_nxt;
    ent_r     <= ent_nxt;
    idx_r     <= idx_nxt;
    probe_n_r <= probe_n_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

/* src/shi_hash.sv */
// two-stage fibonacci hash: home slot from a 64-bit key
// depends on shi_pkg
`timescale 1ns / 1ps
`default_nettype none

module shi_hash (
  input  wire logic                     clk,
  input  wire logic [63:0]              key,
  output logic [shi_pkg::SLOT_W-1:0]    home
);

  localparam int W = shi_pkg::SLOT_W;

  logic [31:0]    kl;
  logic [W-1:0]   kh;
  logic [W-1:0]   kl_lo;
  logic [31:0]    gl;
  logic [W-1:0]   gl_lo;
  logic [W-1:0]   gh;
  logic [2*W-1:0] x0;
  logic [2*W-1:0] x1;

  logic [63:0]    p0_r;
  logic [W-1:0]   cross_r;
  logic [W-1:0]   home_r;

  assign kl    = key[31:0];
  assign kh    = key[32+W-1:32];
  assign kl_lo = key[W-1:0];
  assign gl    = shi_pkg::GOLDEN[31:0];
  assign gl_lo = shi_pkg::GOLDEN[W-1:0];
  assign gh    = shi_pkg::GOLDEN[32+W-1:32];
  assign x0    = kh * gl_lo;
  assign x1    = kl_lo * gh;

  // low word product plus the cross terms that reach the slot bits
  always_ff @(posedge clk) begin
    p0_r    <= 64'(kl) * 64'(gl);
    cross_r <= x0[W-1:0] + x1[W-1:0];
    home_r  <= p0_r[32+W-1:32] + cross_r;
  end

  assign home = home_r;

endmodule

`default_nettype wire

/* src/shi_checker.sv */
// port-level checks of the symbol hash index, bound to the top level
// depends on shi_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module shi_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire shi_pkg::out_t out_item
);

  `SHI_ASSERT_IMP(a_result_when_idle, out_valid, !busy)
  `SHI_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy)
  `SHI_ASSERT_NXT(a_single_strobe, out_valid, !out_valid)
  `SHI_ASSERT_IMP(a_miss_is_zero, out_valid && !out_item.found,
                  out_item.row_out == 8'd0 && !out_item.entry_valid)
  `SHI_ASSERT_IMP(a_absent_entry_zero, out_valid && !out_item.entry_valid,
                  out_item.entry_out == 9'd0)

endmodule

bind symbol_hash_index shi_checker u_shi_checker (.*);

`default_nettype wire

/* bench/symbol_hash_index_test.sv */
`timescale 1ns / 1ps

// self-checking bench for symbol_hash_index: directed rows, a half-full fill, random ops
// keeps its own copy of the slot store and predicts each result a directed row does not give; needs shi_pkg and the rtl
module symbol_hash_index_test;
  import shi_pkg::*;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  // mirror of the slot store
  bit          occupied [SLOTS];
  logic [63:0] stored_key [SLOTS];
  logic [7:0]  stored_row [SLOTS];
  ent_t        monad_ent [SLOTS];
  ent_t        dyad_ent [SLOTS];
  int unsigned fill_count;

  out_t        pending_results [$];
  logic [63:0] key_pool [$];
  stim_row_t   directed_rows [$];
  int          errors;
  int          idle_pct;

  symbol_hash_index dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #10 clk = ~clk;

  function automatic int unsigned home_of(logic [63:0] key);
    logic [63:0] prod;
    prod = key * GOLDEN;
    return int'((prod >> 32) & 64'(SLOTS - 1));
  endfunction

  function automatic logic [63:0] key_homed(int unsigned lo, int unsigned hi);
    logic [63:0] k;
    k = {$urandom, $urandom};
    while (home_of(k) < lo || home_of(k) > hi) k = {$urandom, $urandom};
    return k;
  endfunction

  function automatic out_t slot_view(int unsigned s, logic val);
    out_t r;
    ent_t e;
    e = val ? dyad_ent[s] : monad_ent[s];
    r = '0;
    r.found = 1'b1;
    r.row_out = stored_row[s];
    r.entry_valid = e.valid;
    r.entry_out = e.valid ? e.idx : 9'd0;
    return r;
  endfunction

  // applies one item to the mirror and returns the result the block should give
  function automatic out_t index_apply(in_t it);
    out_t r;
    int unsigned idx, hit, free_at, n;
    bit present, done;
    r = '0;
    if (it.op == OP_CLEAR) begin
      foreach (occupied[i]) occupied[i] = 1'b0;
      fill_count = 0;
      return r;
    end
    idx = home_of(it.key);
    present = 1'b0;
    done = 1'b0;
    free_at = SLOTS;
    hit = 0;
    for (n = 0; n < SLOTS && !done; n++) begin
      if (!occupied[idx]) begin
        free_at = idx;
        done = 1'b1;
      end else if (stored_key[idx] == it.key) begin
        hit = idx;
        present = 1'b1;
        done = 1'b1;
      end else begin
        idx = (idx + 1) % SLOTS;
      end
    end
    if (it.op == OP_LOOKUP) begin
      if (present) r = slot_view(hit, it.valence);
      return r;
    end
    if (!present) begin
      if (fill_count >= HALF || free_at >= SLOTS) begin
        r.status = 1'b1;
        return r;
      end
      hit = free_at;
      fill_count++;
      occupied[hit] = 1'b1;
      stored_key[hit] = it.key;
      monad_ent[hit] = '0;
      dyad_ent[hit] = '0;
    end
    stored_row[hit] = it.row_index & ROW_MASK;
    if (it.op == OP_INSERT_ENT) begin
      if (it.valence) dyad_ent[hit] = '{valid: 1'b1, idx: it.entry_index};
      else monad_ent[hit] = '{valid: 1'b1, idx: it.entry_index};
    end
    return slot_view(hit, it.valence);
  endfunction

  function automatic in_t item_of(logic [1:0] op, logic [63:0] key, logic [7:0] row,
                                  logic val, logic [8:0] ent);
    in_t it;
    it.op = op;
    it.key = key;
    it.row_index = row;
    it.valence = val;
    it.entry_index = ent;
    return it;
  endfunction

  function automatic out_t result_of(logic f, logic [7:0] row, logic ev, logic [8:0] eo,
                                     logic st);
    out_t r;
    r.found = f;
    r.row_out = row;
    r.entry_valid = ev;
    r.entry_out = eo;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(in_t it, bit typed, out_t want);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic logic [63:0] pooled_key(int unsigned new_pct);
    logic [63:0] k;
    if (key_pool.size() == 0 || $urandom_range(99) < new_pct) begin
      k = $urandom_range(1) ? key_homed(504, 511) : {$urandom, $urandom};
      if (key_pool.size() < 64) key_pool.push_back(k);
      return k;
    end
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  function automatic in_t random_item();
    in_t it;
    int unsigned pick;
    it = item_of(OP_LOOKUP, 64'd0, 8'($urandom), 1'($urandom), 9'($urandom));
    pick = $urandom_range(99);
    if (pick < 3) begin
      it.op = OP_CLEAR;
      it.key = {$urandom, $urandom};
    end else if (pick < 50) begin
      it.op = $urandom_range(1) ? OP_INSERT_ENT : OP_INSERT;
      it.key = pooled_key(30);
    end else begin
      it.key = pooled_key(15);
    end
    return it;
  endfunction

  task automatic send(in_t it, bit typed, out_t typed_want);
    out_t want;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    want = index_apply(it);
    pending_results.push_back(typed ? typed_want : want);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic report_field(string name, logic [8:0] want, logic [8:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.found !== want.found)
          report_field("found", want.found, out_item.found);
        if (out_item.row_out !== want.row_out)
          report_field("row_out", want.row_out, out_item.row_out);
        if (out_item.entry_valid !== want.entry_valid)
          report_field("entry_valid", want.entry_valid, out_item.entry_valid);
        if (out_item.entry_out !== want.entry_out)
          report_field("entry_out", want.entry_out, out_item.entry_out);
        if (out_item.status !== want.status)
          report_field("status", want.status, out_item.status);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [63:0] k, w0, w1, w2;
    logic [63:0] fill_keys [$];
    out_t none;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    errors = 0;
    fill_count = 0;
    idle_pct = 24;
    none = '0;
    w0 = key_homed(SLOTS - 1, SLOTS - 1);
    w1 = key_homed(SLOTS - 1, SLOTS - 1);
    w2 = key_homed(SLOTS - 1, SLOTS - 1);

    // empty table, extremes, both valences, probing across the last slot, clear
    add_row(item_of(OP_LOOKUP, 64'd0, 8'd0, 1'b0, 9'd0), 1, none);
    add_row(item_of(OP_LOOKUP, '1, 8'hff, 1'b1, 9'h1ff), 1, none);
    add_row(item_of(OP_INSERT, 64'd0, 8'hff, 1'b0, 9'h1ff), 1,
            result_of(1, 8'hff, 0, 9'd0, 0));
    add_row(item_of(OP_LOOKUP, 64'd0, 8'd0, 1'b1, 9'd0), 1, result_of(1, 8'hff, 0, 9'd0, 0));
    add_row(item_of(OP_INSERT_ENT, '1, 8'd0, 1'b1, 9'h1ff), 1,
            result_of(1, 8'd0, 1, 9'h1ff, 0));
    add_row(item_of(OP_LOOKUP, '1, 8'd0, 1'b0, 9'd0), 1, result_of(1, 8'd0, 0, 9'd0, 0));
    add_row(item_of(OP_LOOKUP, '1, 8'd0, 1'b1, 9'd0), 1, result_of(1, 8'd0, 1, 9'h1ff, 0));
    add_row(item_of(OP_INSERT_ENT, '1, 8'haa, 1'b0, 9'd0), 1,
            result_of(1, 8'haa, 1, 9'd0, 0));
    add_row(item_of(OP_LOOKUP, '1, 8'd0, 1'b1, 9'd0), 1, result_of(1, 8'haa, 1, 9'h1ff, 0));
    add_row(item_of(OP_INSERT, 64'd0, 8'h55, 1'b1, 9'h0aa), 0, none);
    add_row(item_of(OP_INSERT_ENT, w0, 8'h11, 1'b0, 9'h101), 0, none);
    add_row(item_of(OP_INSERT_ENT, w1, 8'h22, 1'b1, 9'h0fe), 0, none);
    add_row(item_of(OP_INSERT_ENT, w2, 8'h33, 1'b0, 9'h155), 0, none);
    add_row(item_of(OP_LOOKUP, w0, 8'd0, 1'b0, 9'd0), 0, none);
    add_row(item_of(OP_LOOKUP, w1, 8'd0, 1'b1, 9'd0), 0, none);
    add_row(item_of(OP_LOOKUP, w2, 8'd0, 1'b0, 9'd0), 0, none);
    add_row(item_of(OP_INSERT_ENT, w1, 8'h80, 1'b0, 9'h0aa), 0, none);
    add_row(item_of(OP_LOOKUP, w1, 8'd0, 1'b1, 9'd0), 0, none);
    add_row(item_of(OP_CLEAR, 64'h5a5a_a5a5_f0f0_0f0f, 8'h5a, 1'b1, 9'h155), 1, none);
    add_row(item_of(OP_LOOKUP, w1, 8'd0, 1'b0, 9'd0), 1, none);
    add_row(item_of(OP_LOOKUP, 64'd0, 8'd0, 1'b0, 9'd0), 1, none);
    add_row(item_of(OP_INSERT, w2, 8'h7f, 1'b1, 9'd0), 0, none);
    add_row(item_of(OP_LOOKUP, w2, 8'd0, 1'b0, 9'd0), 0, none);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain();

    // fill to half, then refused inserts, updates and lookups at full load
    send(item_of(OP_CLEAR, {$urandom, $urandom}, 8'($urandom), 1'b0, 9'($urandom)), 1, none);
    while (fill_count < HALF) begin
      k = {$urandom, $urandom};
      fill_keys.push_back(k);
      send(item_of($urandom_range(1) ? OP_INSERT_ENT : OP_INSERT, k, 8'($urandom),
                   1'($urandom), 9'($urandom)), 0, none);
    end
    repeat (8)
      send(item_of($urandom_range(1) ? OP_INSERT_ENT : OP_INSERT, {$urandom, $urandom},
                   8'($urandom), 1'($urandom), 9'($urandom)), 0, none);
    repeat (12)
      send(item_of($urandom_range(1) ? OP_INSERT_ENT : OP_INSERT,
                   fill_keys[$urandom_range(fill_keys.size() - 1)], 8'($urandom),
                   1'($urandom), 9'($urandom)), 0, none);
    repeat (12)
      send(item_of(OP_LOOKUP, fill_keys[$urandom_range(fill_keys.size() - 1)],
                   8'($urandom), 1'($urandom), 9'($urandom)), 0, none);
    repeat (4)
      send(item_of(OP_LOOKUP, {$urandom, $urandom}, 8'($urandom), 1'($urandom),
                   9'($urandom)), 0, none);
    drain();

    // random ops on a small key pool, half of it crowded near the last slot
    for (int phase = 0; phase < 2; phase++) begin
      idle_pct = (phase == 0) ? 74 : 0;
      key_pool.delete();
      send(item_of(OP_CLEAR, {$urandom, $urandom}, 8'($urandom), 1'($urandom),
                   9'($urandom)), 1, none);
      repeat (118) send(random_item(), 0, none);
      drain();
    end

    repeat (SLOTS + 16) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
